>>> hw/rtl/u8ss_pkg.sv
// ----------------------------------------------------------------------------
// u8ss_pkg
// Shared constants, command codes and inter-module types for the UTF-8
// substring search block.
// ----------------------------------------------------------------------------
package u8ss_pkg;

   // pattern store depth and index counter width
   localparam int PATTERN_MAX = 64;
   localparam int INDEX_W     = 24;
   localparam int POS_W       = 24;

   // pattern length / window fill count holds 0..PATTERN_MAX
   localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
   // slot select, 0..PATTERN_MAX-1
   localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_START   = 2'd0,
      CMD_PATTERN = 2'd1,
      CMD_TEXT    = 2'd2,
      CMD_END     = 2'd3
   } cmd_type;

   // classified operation handed from front to back
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
      logic       char_start;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

>>> hw/rtl/u8ss_ifs.sv
// ----------------------------------------------------------------------------
// u8ss channel interfaces
// Valid/ready channels for the request (command) and response (result) sides.
// ----------------------------------------------------------------------------
interface u8ss_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] byte_value;

   modport source (output valid, output cmd, output byte_value, input ready);
   modport sink   (input valid, input cmd, input byte_value, output ready);
endinterface

interface u8ss_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic [u8ss_pkg::POS_W-1:0] position;
   logic                      error;

   modport source (output valid, output found, output position, output error,
                   input ready);
   modport sink   (input valid, input found, input position, input error,
                   output ready);
endinterface

>>> hw/rtl/u8ss_queue.sv
// ----------------------------------------------------------------------------
// u8ss_queue
// Short FIFO of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module u8ss_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  u8ss_pkg::op_type     push_op,
   input  logic                 pop,
   output u8ss_pkg::op_type     head_op,
   output u8ss_pkg::q_stat_type stat
);

   u8ss_pkg::op_type                  mem_ff [u8ss_pkg::QUEUE_DEPTH];
   logic [u8ss_pkg::QPTR_W-1:0]       head_ff, head_in;
   logic [u8ss_pkg::QPTR_W-1:0]       tail_ff, tail_in;
   logic [u8ss_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign stat.full  = (count_ff == u8ss_pkg::QCNT_W'(u8ss_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_op    = mem_ff[head_ff];

   always_comb begin
      do_push = push_valid && !stat.full;
      do_pop  = pop && !stat.empty;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == u8ss_pkg::QPTR_W'(u8ss_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : tail_ff + u8ss_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == u8ss_pkg::QPTR_W'(u8ss_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : head_ff + u8ss_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + u8ss_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - u8ss_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail_ff] <= push_op;
      end
   end

endmodule

>>> hw/rtl/u8ss_front.sv
// ----------------------------------------------------------------------------
// u8ss_front
// Accepts commands, marks text bytes that open a character and queues them.
// ----------------------------------------------------------------------------
module u8ss_front (
   input  logic                 clock,
   input  logic                 reset,
   u8ss_req_if.sink             req,
   input  logic                 utf8_mode,
   input  u8ss_pkg::q_stat_type q_stat,
   output logic                 push_valid,
   output u8ss_pkg::op_type     push_op
);

   logic              text_seen_ff, text_seen_in;
   logic              accept;
   u8ss_pkg::cmd_type cmd;

   assign req.ready = !q_stat.full;

   always_comb begin
      cmd    = u8ss_pkg::cmd_type'(req.cmd);
      accept = req.valid && req.ready;
      push_valid = accept;
      push_op.cmd  = cmd;
      push_op.data = req.byte_value;
      // first text byte of a search always opens a character
      push_op.char_start = !utf8_mode || !text_seen_ff || (req.byte_value[7:6] != 2'b10);
      text_seen_in = text_seen_ff;
      if (accept) begin
         unique case (cmd)
            u8ss_pkg::CMD_START: text_seen_in = 1'b0;
            u8ss_pkg::CMD_TEXT:  text_seen_in = 1'b1;
            default:             text_seen_in = text_seen_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_seen_ff <= 1'b0;
      end else begin
         text_seen_ff <= text_seen_in;
      end
   end

endmodule

>>> hw/rtl/u8ss_back.sv
// ----------------------------------------------------------------------------
// u8ss_back
// Pattern store, sliding text window with parallel compare cells, index
// counters and the result register.
// ----------------------------------------------------------------------------
module u8ss_back (
   input  logic                 clock,
   input  logic                 reset,
   input  u8ss_pkg::op_type     head_op,
   input  u8ss_pkg::q_stat_type q_stat,
   output logic                 pop,
   u8ss_rsp_if.source           rsp
);

   localparam int PM = u8ss_pkg::PATTERN_MAX;

   // pattern held newest-first so it lines up with the window
   logic [7:0]                    pat_ff [PM];
   logic [7:0]                    pat_in [PM];
   logic [7:0]                    win_ff [PM];
   logic [7:0]                    win_in [PM];
   logic [u8ss_pkg::INDEX_W-1:0]  sidx_ff [PM];
   logic [u8ss_pkg::INDEX_W-1:0]  sidx_in [PM];
   logic [PM-1:0]                 cs_ff, cs_in;

   logic [u8ss_pkg::PLEN_W-1:0]   len_ff, len_in;
   logic [u8ss_pkg::PLEN_W-1:0]   fill_ff, fill_in;
   logic [u8ss_pkg::INDEX_W-1:0]  pos_ff, pos_in;
   logic                          match_ff, match_in;
   logic [u8ss_pkg::INDEX_W-1:0]  mpos_ff, mpos_in;
   logic                          ovf_ff, ovf_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          found_ff, found_in;
   logic [u8ss_pkg::POS_W-1:0]    rpos_ff, rpos_in;
   logic                          err_ff, err_in;

   logic [7:0]                    slot_new [PM];
   logic [u8ss_pkg::INDEX_W-1:0]  idx_new [PM];
   logic [PM-1:0]                 start_new;
   logic                          all_eq;
   logic [u8ss_pkg::PIDX_W-1:0]   sel;
   logic [u8ss_pkg::PLEN_W-1:0]   fill_next;
   logic                          hit;
   logic                          take;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = found_ff;
   assign rsp.position = rpos_ff;
   assign rsp.error    = err_ff;

   // compare cells: window as it stands after this text byte
   always_comb begin
      slot_new[0]  = head_op.data;
      idx_new[0]   = pos_ff;
      start_new[0] = head_op.char_start;
      for (int k = 1; k < PM; k++) begin
         slot_new[k]  = win_ff[k-1];
         idx_new[k]   = sidx_ff[k-1];
         start_new[k] = cs_ff[k-1];
      end
      all_eq = 1'b1;
      for (int k = 0; k < PM; k++) begin
         if ((u8ss_pkg::PLEN_W'(k) < len_ff) && (slot_new[k] != pat_ff[k])) begin
            all_eq = 1'b0;
         end
      end
      sel = u8ss_pkg::PIDX_W'(len_ff - u8ss_pkg::PLEN_W'(1));
      fill_next = (fill_ff == u8ss_pkg::PLEN_W'(PM)) ? fill_ff :
                  fill_ff + u8ss_pkg::PLEN_W'(1);
      hit = !match_ff && (len_ff != '0) && (fill_next >= len_ff) && all_eq &&
            start_new[sel];
   end

   always_comb begin
      take = !q_stat.empty &&
             ((head_op.cmd != u8ss_pkg::CMD_END) || !rsp_valid_ff || rsp.ready);
      pop = take;

      pat_in   = pat_ff;
      win_in   = win_ff;
      sidx_in  = sidx_ff;
      cs_in    = cs_ff;
      len_in   = len_ff;
      fill_in  = fill_ff;
      pos_in   = pos_ff;
      match_in = match_ff;
      mpos_in  = mpos_ff;
      ovf_in   = ovf_ff;
      found_in = found_ff;
      rpos_in  = rpos_ff;
      err_in   = err_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;

      if (take) begin
         unique case (head_op.cmd)
            u8ss_pkg::CMD_START: begin
               len_in   = '0;
               fill_in  = '0;
               pos_in   = '0;
               match_in = 1'b0;
               mpos_in  = '0;
               ovf_in   = 1'b0;
            end
            u8ss_pkg::CMD_PATTERN: begin
               if (len_ff < u8ss_pkg::PLEN_W'(PM)) begin
                  pat_in[0] = head_op.data;
                  for (int k = 1; k < PM; k++) begin
                     pat_in[k] = pat_ff[k-1];
                  end
                  len_in = len_ff + u8ss_pkg::PLEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            u8ss_pkg::CMD_TEXT: begin
               win_in  = slot_new;
               sidx_in = idx_new;
               cs_in   = start_new;
               fill_in = fill_next;
               if (head_op.char_start && (pos_ff != u8ss_pkg::INDEX_MAX)) begin
                  pos_in = pos_ff + u8ss_pkg::INDEX_W'(1);
               end
               if (hit) begin
                  match_in = 1'b1;
                  mpos_in  = idx_new[sel];
               end
            end
            u8ss_pkg::CMD_END: begin
               rsp_valid_in = 1'b1;
               if (ovf_ff) begin
                  found_in = 1'b0;
                  rpos_in  = '0;
                  err_in   = 1'b1;
               end else if (len_ff == '0) begin
                  found_in = 1'b1;
                  rpos_in  = '0;
                  err_in   = 1'b0;
               end else if (match_ff) begin
                  found_in = 1'b1;
                  rpos_in  = u8ss_pkg::POS_W'(mpos_ff);
                  err_in   = 1'b0;
               end else begin
                  found_in = 1'b0;
                  rpos_in  = '0;
                  err_in   = 1'b0;
               end
            end
            default: begin
               rsp_valid_in = rsp_valid_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         match_ff     <= 1'b0;
         mpos_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         match_ff     <= match_in;
         mpos_ff      <= mpos_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: window slots beyond the fill count are never looked at
   always_ff @(posedge clock) begin
      pat_ff   <= pat_in;
      win_ff   <= win_in;
      sidx_ff  <= sidx_in;
      cs_ff    <= cs_in;
      found_ff <= found_in;
      rpos_ff  <= rpos_in;
      err_ff   <= err_in;
   end

endmodule

>>> hw/rtl/utf8_substring_search.sv
// ----------------------------------------------------------------------------
// utf8_substring_search
// Streaming first-occurrence substring search over UTF-8 or byte text.
//
//   channel   dir  handshake             payload
//   req_chan  in   valid/ready           cmd[1:0], byte_value[7:0]
//   rsp_chan  out  valid/ready           found, position[23:0], error
//   csr       in   csr_wr_en             csr_wr_data (utf8_mode)
//
// One command is taken per cycle while the queue is not full; a text byte is
// compared against the whole pattern at once by a row of byte compare cells.
// A result is offered once its end of text has passed through the queue and
// been taken into the result register by the back end.
// While a result waits untaken, the next end of text stops at the queue head
// and the request side stalls once the two-entry queue is full.
// Synchronous reset; no clearing pass, a fill count guards the window.
// ----------------------------------------------------------------------------
module utf8_substring_search (
   input  logic        clock,
   input  logic        reset,
   u8ss_req_if.sink    req_chan,
   u8ss_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                 utf8_mode_ff, utf8_mode_in;
   logic                 push_valid;
   u8ss_pkg::op_type     push_op;
   u8ss_pkg::op_type     head_op;
   u8ss_pkg::q_stat_type q_stat;
   logic                 pop;

   assign utf8_mode_in = csr_wr_en ? csr_wr_data : utf8_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         utf8_mode_ff <= 1'b1;
      end else begin
         utf8_mode_ff <= utf8_mode_in;
      end
   end

   u8ss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .utf8_mode  (utf8_mode_ff),
      .q_stat     (q_stat),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   u8ss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .pop        (pop),
      .head_op    (head_op),
      .stat       (q_stat)
   );

   u8ss_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head_op (head_op),
      .q_stat  (q_stat),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

`ifndef SYNTH
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.error |-> !rsp_chan.found && (rsp_chan.position == '0))
      else $error("error result carries found or a position");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.found |-> rsp_chan.position == '0)
      else $error("miss result with non-zero position");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> $past(push_valid) || $past(q_stat.full))
      else $error("request side stalled without queue fill");
`endif

endmodule

>>> bench/tb_utf8_substring_search.sv
// ----------------------------------------------------------------------------
// tb_utf8_substring_search
// Self-checking bench for the streaming substring search. Commands are
// driven over the request channel with random gaps. A scoreboard class keeps
// its own copy of the search state, works out the result of every end of
// text and compares each response transfer field by field. The run changes
// between UTF-8 and byte mode between phases, holds the response side off
// long enough to back up the request channel, and ends with a phase without
// idling.
// ----------------------------------------------------------------------------
module tb_utf8_substring_search;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS_TARGET = 1850;
   localparam int CHUNK_ITEMS  = 160;
   localparam int SETTLE_LEN   = 8;     // covers the queue and result register, with margin
   localparam int LONG_HOLD    = 300;

   typedef struct packed {
      logic                       found;
      logic [u8ss_pkg::POS_W-1:0] position;
      logic                       error;
   } search_report_type;

   // ------------------------------------------------------------------------
   // Search state tracker: follows every request transfer, queues the report
   // each end of text should produce and checks response transfers.
   // ------------------------------------------------------------------------
   class scoreboard_type;
      bit                         utf8_mode;
      bit [7:0]                   pattern_bytes [u8ss_pkg::PATTERN_MAX];
      int unsigned                pattern_len;
      bit [7:0]                   window_bytes  [u8ss_pkg::PATTERN_MAX];
      bit                         window_start  [u8ss_pkg::PATTERN_MAX];
      bit [u8ss_pkg::INDEX_W-1:0] window_index  [u8ss_pkg::PATTERN_MAX];
      bit [u8ss_pkg::INDEX_W-1:0] byte_count;
      bit [u8ss_pkg::INDEX_W-1:0] char_count;
      bit                         hit_seen;
      bit [u8ss_pkg::INDEX_W-1:0] hit_index;
      bit                         overflowed;
      search_report_type          pending_reports [$];
      int                         errors;

      function new();
         utf8_mode = 1'b1;
         errors = 0;
         clear_search();
      endfunction

      function void set_mode(bit m);
         utf8_mode = m;
      endfunction

      function void clear_search();
         for (int i = 0; i < u8ss_pkg::PATTERN_MAX; i++) begin
            pattern_bytes[i] = '0;
            window_bytes[i] = '0;
            window_start[i] = 1'b0;
            window_index[i] = '0;
         end
         pattern_len = 0;
         byte_count = '0;
         char_count = '0;
         hit_seen = 1'b0;
         hit_index = '0;
         overflowed = 1'b0;
      endfunction

      function void shift_text(bit [7:0] b);
         bit          is_start;
         bit          ok;
         int unsigned m;
         is_start = utf8_mode ? ((byte_count == 0) || (b[7:6] != 2'b10)) : 1'b1;
         for (int i = u8ss_pkg::PATTERN_MAX - 1; i > 0; i--) begin
            window_bytes[i] = window_bytes[i-1];
            window_start[i] = window_start[i-1];
            window_index[i] = window_index[i-1];
         end
         window_bytes[0] = b;
         window_start[0] = is_start;
         window_index[0] = char_count;
         if (byte_count != u8ss_pkg::INDEX_MAX)
            byte_count++;
         if (is_start && char_count != u8ss_pkg::INDEX_MAX)
            char_count++;
         if (!hit_seen && pattern_len > 0 && byte_count >= pattern_len) begin
            m = pattern_len;
            ok = window_start[m-1];
            for (int j = 0; j < m; j++)
               if (window_bytes[m-1-j] != pattern_bytes[j])
                  ok = 1'b0;
            if (ok) begin
               hit_seen = 1'b1;
               hit_index = window_index[m-1];
            end
         end
      endfunction

      function void note_request(u8ss_pkg::cmd_type c, bit [7:0] b);
         search_report_type rep;
         case (c)
            u8ss_pkg::CMD_START: clear_search();
            u8ss_pkg::CMD_PATTERN: begin
               if (pattern_len < u8ss_pkg::PATTERN_MAX) begin
                  pattern_bytes[pattern_len] = b;
                  pattern_len++;
               end else
                  overflowed = 1'b1;
            end
            u8ss_pkg::CMD_TEXT: shift_text(b);
            default: begin
               rep = '0;
               if (overflowed)
                  rep.error = 1'b1;
               else if (pattern_len == 0)
                  rep.found = 1'b1;
               else if (hit_seen) begin
                  rep.found = 1'b1;
                  rep.position = hit_index[u8ss_pkg::POS_W-1:0];
               end
               pending_reports.push_back(rep);
            end
         endcase
      endfunction

      function void check_result(logic f, logic [u8ss_pkg::POS_W-1:0] p, logic e);
         search_report_type want;
         if (pending_reports.size() == 0) begin
            $error("unexpected result: found=%0b position=%0d error=%0b", f, p, e);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         if (f !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, f);
            errors++;
         end
         if (p !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, p);
            errors++;
         end
         if (e !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, e);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_reports.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   u8ss_req_if req_if();
   u8ss_rsp_if rsp_if();

   scoreboard_type sb = new();

   int gap_pct = 25;
   bit hold_request = 1'b0;
   int items_sent = 0;

   always #6 clock = ~clock;

   utf8_substring_search uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic send_cmd(input u8ss_pkg::cmd_type c, input logic [7:0] b);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.cmd        <= c;
      req_if.byte_value <= b;
      do
         @(posedge clock);
      while (!req_if.ready);
      sb.note_request(c, b);
      items_sent++;
   endtask

   // nothing may be in flight when the mode register is written
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_LEN) @(posedge clock);
   endtask

   task automatic write_mode(input bit m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_mode(m);
      @(posedge clock);
   endtask

   // alphabets: 0 anything, 1 two letters, 2 UTF-8 lead/continuation mix,
   // 3 boundary values
   function automatic logic [7:0] pick_byte(int style);
      case (style)
         1: return $urandom_range(0, 1) ? 8'h61 : 8'h62;
         2: case ($urandom_range(0, 5))
               0: return 8'h61;
               1: return 8'hC3;
               2: return 8'hA9;
               3: return 8'h80;
               4: return 8'hBF;
               default: return 8'hE2;
            endcase
         3: case ($urandom_range(0, 3))
               0: return 8'h00;
               1: return 8'hFF;
               2: return 8'h80;
               default: return 8'h7F;
            endcase
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // start, pattern, text with a planted copy more often than not, end, at times more text and another end
   task automatic random_search();
      logic [7:0] pat [$];
      int style, plen, roll, lead, tail, i;
      style = $urandom_range(0, 3);
      roll = $urandom_range(0, 99);
      if (roll < 5)
         plen = 0;
      else if (roll < 80)
         plen = $urandom_range(1, 4);
      else if (roll < 94)
         plen = $urandom_range(5, 16);
      else
         plen = $urandom_range(u8ss_pkg::PATTERN_MAX - 2, u8ss_pkg::PATTERN_MAX + 2);
      for (i = 0; i < plen; i++)
         pat.push_back(pick_byte(style));
      send_cmd(u8ss_pkg::CMD_START, pick_byte(0));
      foreach (pat[k])
         send_cmd(u8ss_pkg::CMD_PATTERN, pat[k]);
      lead = $urandom_range(0, 12);
      tail = $urandom_range(0, 6);
      for (i = 0; i < lead; i++)
         send_cmd(u8ss_pkg::CMD_TEXT, pick_byte(style));
      if ($urandom_range(0, 3) != 0)
         foreach (pat[k])
            send_cmd(u8ss_pkg::CMD_TEXT, pat[k]);
      for (i = 0; i < tail; i++)
         send_cmd(u8ss_pkg::CMD_TEXT, pick_byte(style));
      // late pattern growth
      if ($urandom_range(0, 9) == 0) begin
         send_cmd(u8ss_pkg::CMD_PATTERN, pick_byte(style));
         send_cmd(u8ss_pkg::CMD_TEXT, pick_byte(style));
      end
      send_cmd(u8ss_pkg::CMD_END, pick_byte(0));
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(0, 5))
            send_cmd(u8ss_pkg::CMD_TEXT, pick_byte(style));
         send_cmd(u8ss_pkg::CMD_END, pick_byte(0));
      end
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(1, 6))
         send_cmd(u8ss_pkg::cmd_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
   endtask

   // response side held off while ends of text keep coming: request must stall
   task automatic stuff_queue();
      hold_request = 1'b1;
      send_cmd(u8ss_pkg::CMD_START, 8'h00);
      send_cmd(u8ss_pkg::CMD_PATTERN, 8'h61);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'h61);
      repeat (8) begin
         send_cmd(u8ss_pkg::CMD_END, 8'h00);
         send_cmd(u8ss_pkg::CMD_TEXT, pick_byte(1));
      end
      drain_results();
   endtask

   task automatic directed_checks();
      send_cmd(u8ss_pkg::CMD_END, 8'h00);          // empty pattern, empty text
      send_cmd(u8ss_pkg::CMD_START, 8'hFF);
      send_cmd(u8ss_pkg::CMD_PATTERN, 8'hC3);
      send_cmd(u8ss_pkg::CMD_PATTERN, 8'hA9);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'h41);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'hC3);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'hA9);
      send_cmd(u8ss_pkg::CMD_END, 8'h00);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'h80);
      send_cmd(u8ss_pkg::CMD_END, 8'hFF);          // repeated end of text
      // continuation byte first in the text still counts as a start
      send_cmd(u8ss_pkg::CMD_START, 8'h00);
      send_cmd(u8ss_pkg::CMD_PATTERN, 8'h80);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'h80);
      send_cmd(u8ss_pkg::CMD_END, 8'h00);
      // pattern grows after text has begun
      send_cmd(u8ss_pkg::CMD_START, 8'h00);
      send_cmd(u8ss_pkg::CMD_PATTERN, 8'h42);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'h41);
      send_cmd(u8ss_pkg::CMD_PATTERN, 8'h43);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'h42);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'h43);
      send_cmd(u8ss_pkg::CMD_END, 8'h00);
      // no match
      send_cmd(u8ss_pkg::CMD_START, 8'h00);
      send_cmd(u8ss_pkg::CMD_PATTERN, 8'h41);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'h42);
      send_cmd(u8ss_pkg::CMD_END, 8'h00);
      // mode switched part way through a search
      send_cmd(u8ss_pkg::CMD_START, 8'h00);
      send_cmd(u8ss_pkg::CMD_PATTERN, 8'h81);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'hC3);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'h81);
      drain_results();
      write_mode(1'b0);
      send_cmd(u8ss_pkg::CMD_TEXT, 8'h81);
      send_cmd(u8ss_pkg::CMD_END, 8'h00);
      drain_results();
      write_mode(1'b1);
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.found, rsp_if.position, rsp_if.error);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_if.ready <= 1'b0;
         end else
            rsp_if.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      int chunk;
      int chunk_end;
      int waited;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_if.valid = 1'b0;
      req_if.cmd = u8ss_pkg::CMD_START;
      req_if.byte_value = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);
      write_mode(1'b1);

      directed_checks();

      chunk = 0;
      while (items_sent < ITEMS_TARGET) begin
         drain_results();
         write_mode(1'(chunk % 2));
         if (items_sent >= ITEMS_TARGET - 250)
            gap_pct = 0;
         else
            gap_pct = (chunk % 3 == 2) ? 0 : 25;
         if (chunk == 1)
            stuff_queue();
         chunk_end = items_sent + CHUNK_ITEMS;
         if (chunk_end > ITEMS_TARGET)
            chunk_end = ITEMS_TARGET;
         while (items_sent < chunk_end) begin
            if ($urandom_range(0, 9) == 0)
               noise_burst();
            else
               random_search();
         end
         chunk++;
      end
      req_if.valid <= 1'b0;

      waited = 0;
      while (sb.outstanding() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_LEN) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $error("%0d results never arrived", sb.outstanding());
         sb.errors++;
      end

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
